// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while the synchronous reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ----- hw/rtl/pott_pkg.sv -----
`timescale 1ns / 1ps

package pott_pkg;

    localparam int SLOT_W = 5;
    localparam logic [7:0] MIN_STACK_RESET = 8'd32;

    localparam logic [3:0] FLAG_REMOTE  = 4'b0001;
    localparam logic [3:0] FLAG_PEND    = 4'b0010;
    localparam logic [3:0] FLAG_SUSP    = 4'b0100;
    localparam logic [3:0] FLAG_TIMEOUT = 4'b1000;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_PEND    = 3'd3,
        CMD_SUSPEND = 3'd4,
        CMD_RESUME  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_ID_EXISTS   = 3'd1,
        STAT_PRI_EXISTS  = 3'd2,
        STAT_FULL        = 3'd3,
        STAT_NOT_FOUND   = 3'd4,
        STAT_STACK_SMALL = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SET    = 3'd3,
        OP_CLR    = 3'd4
    } t_op_kind;

    // Update broadcast to every cell.
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] id;
        logic [7:0] pri;
        logic [3:0] flags;
    } t_op;

    // Contents of one slot, also what moves between neighbors on a shift.
    typedef struct packed {
        logic       live;
        logic [3:0] flags;
        logic [7:0] pri;
        logic [7:0] id;
    } t_entry;

    localparam t_entry ENTRY_EMPTY = '0;

    // Registered compare results of one cell.
    typedef struct packed {
        logic id_hit;
        logic pri_hit;
        logic pri_gt;
        logic remote;
    } t_match;

endpackage

// ----- hw/rtl/pott_cell.sv -----
`timescale 1ns / 1ps

module pott_cell #(
    parameter int ENTRIES = 16,
    parameter int INDEX   = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_key_id,
    input  logic [7:0]             i_key_pri,
    input  pott_pkg::t_op          i_op,
    input  logic [$clog2(ENTRIES)-1:0] i_pos,
    input  pott_pkg::t_entry       i_prev,
    input  pott_pkg::t_entry       i_next,
    output pott_pkg::t_entry       o_entry,
    output pott_pkg::t_match       o_match
);
    import pott_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    t_entry r_entry;
    t_entry n_entry;
    t_match r_match;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op.kind)
            OP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_entry = i_prev;
                end else if (MY_IDX == i_pos) begin
                    n_entry.live  = 1'b1;
                    n_entry.flags = i_op.flags;
                    n_entry.pri   = i_op.pri;
                    n_entry.id    = i_op.id;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_entry = i_next;
                end
            end
            OP_SET: begin
                if (MY_IDX == i_pos) begin
                    n_entry.flags = r_entry.flags | i_op.flags;
                end
            end
            OP_CLR: begin
                if (MY_IDX == i_pos) begin
                    n_entry.flags = r_entry.flags & ~i_op.flags;
                end
            end
            default: ;
        endcase
    end

    // id and priority carry no reset, only live and flags do
    always_ff @(posedge i_clk) begin
        r_entry.pri <= n_entry.pri;
        r_entry.id  <= n_entry.id;
        if (!i_rst_n) begin
            r_entry.live  <= 1'b0;
            r_entry.flags <= '0;
        end else begin
            r_entry.live  <= n_entry.live;
            r_entry.flags <= n_entry.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else begin
            r_match.id_hit  <= r_entry.live && (r_entry.id == i_key_id);
            r_match.pri_hit <= r_entry.live && (r_entry.pri == i_key_pri);
            r_match.pri_gt  <= r_entry.live && (r_entry.pri > i_key_pri);
            r_match.remote  <= r_entry.live && ((r_entry.flags & FLAG_REMOTE) != '0);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ----- hw/rtl/pott_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pott_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [2:0]                 i_command,
    input  logic [7:0]                 i_task_id,
    input  logic [7:0]                 i_task_priority,
    input  logic [7:0]                 i_stack_bytes,
    input  logic                       i_local_task,
    input  logic                       i_cfg_we,
    input  logic [7:0]                 i_cfg_wdata,
    input  pott_pkg::t_match           i_match [ENTRIES],
    output logic [7:0]                 o_key_id,
    output logic [7:0]                 o_key_pri,
    output pott_pkg::t_op              o_op,
    output logic [$clog2(ENTRIES)-1:0] o_pos,
    output logic                       o_done,
    output logic [2:0]                 o_status_code,
    output logic [pott_pkg::SLOT_W-1:0] o_slot_index,
    output logic [pott_pkg::SLOT_W-1:0] o_task_count
);
    import pott_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] SLOT_NONE = CW'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_ACT  = 3'b100
    } t_state;

    t_state        r_state;
    logic          r_done;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_min_stack;
    t_cmd          r_cmd;
    logic [7:0]    r_id;
    logic [7:0]    r_pri;
    logic [7:0]    r_stk;
    logic          r_local;
    t_status       r_status;
    t_status       n_status;
    logic [CW-1:0] r_slot;
    logic [CW-1:0] n_slot;

    logic [ENTRIES-1:0] id_v;
    logic [ENTRIES-1:0] pri_v;
    logic [ENTRIES-1:0] gt_v;
    logic [ENTRIES-1:0] rmt_v;
    logic [ENTRIES-1:0] hit_v;
    logic [ENTRIES-1:0] first_hit;
    logic [ENTRIES-1:0] first_id;
    logic [ENTRIES-1:0] first_gt;
    logic [IW-1:0]      id_pos;
    logic               found;
    logic               is_remote;
    logic               full;
    t_op                op;
    logic [IW-1:0]      pos;

    function automatic logic [IW-1:0] enc(input logic [ENTRIES-1:0] oh);
        logic [IW-1:0] res;
        res = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (oh[i]) begin
                res = res | IW'(i);
            end
        end
        return res;
    endfunction

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            id_v[i]  = i_match[i].id_hit;
            pri_v[i] = i_match[i].pri_hit;
            gt_v[i]  = i_match[i].pri_gt;
            rmt_v[i] = i_match[i].remote;
        end
    end

    // lowest set bit isolates the first matching slot
    assign hit_v     = id_v | pri_v;
    assign first_hit = hit_v & (~hit_v + ENTRIES'(1));
    assign first_id  = id_v & (~id_v + ENTRIES'(1));
    assign first_gt  = gt_v & (~gt_v + ENTRIES'(1));
    assign id_pos    = enc(first_id);
    assign found     = |id_v;
    assign is_remote = |(first_id & rmt_v);
    assign full      = (r_count >= CW'(ENTRIES));

    always_comb begin
        n_status  = STAT_NOT_FOUND;
        n_slot    = SLOT_NONE;
        n_count   = r_count;
        op.kind   = OP_NONE;
        op.id     = r_id;
        op.pri    = r_pri;
        op.flags  = '0;
        pos       = id_pos;
        unique case (r_cmd)
            CMD_CREATE: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else if (r_stk <= r_min_stack) begin
                    n_status = STAT_STACK_SMALL;
                end else if (|hit_v) begin
                    n_status = (|(first_hit & id_v)) ? STAT_ID_EXISTS : STAT_PRI_EXISTS;
                end else begin
                    n_status = STAT_OK;
                    pos      = (|gt_v) ? enc(first_gt) : r_count[IW-1:0];
                    op.kind  = OP_INSERT;
                    op.flags = r_local ? 4'b0000 : FLAG_REMOTE;
                    n_slot   = CW'(pos);
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (found) begin
                    n_status = STAT_OK;
                    n_slot   = CW'(id_pos);
                    if (!is_remote) begin
                        op.kind = OP_REMOVE;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            CMD_LOOKUP: begin
                if (found) begin
                    n_status = STAT_OK;
                    n_slot   = CW'(id_pos);
                end
            end
            CMD_PEND: begin
                if (found) begin
                    n_status = STAT_OK;
                    n_slot   = CW'(id_pos);
                    op.kind  = OP_SET;
                    op.flags = FLAG_PEND;
                end
            end
            CMD_SUSPEND: begin
                if (found) begin
                    n_status = STAT_OK;
                    n_slot   = CW'(id_pos);
                    op.kind  = OP_SET;
                    op.flags = FLAG_SUSP;
                end
            end
            CMD_RESUME: begin
                if (found) begin
                    n_status = STAT_OK;
                    n_slot   = CW'(id_pos);
                    op.kind  = OP_CLR;
                    op.flags = FLAG_PEND | FLAG_SUSP | FLAG_TIMEOUT;
                end
            end
            default: ;
        endcase
        if (r_state != S_ACT) begin
            op.kind = OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_min_stack <= MIN_STACK_RESET;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_min_stack <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    r_count <= n_count;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd   <= t_cmd'(i_command);
            r_id    <= i_task_id;
            r_pri   <= i_task_priority;
            r_stk   <= i_stack_bytes;
            r_local <= i_local_task;
        end
        if (r_state == S_ACT) begin
            r_status <= n_status;
            r_slot   <= n_slot;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_key_id      = r_id;
    assign o_key_pri     = r_pri;
    assign o_op          = op;
    assign o_pos         = pos;
    assign o_done        = r_done;
    assign o_status_code = r_status;
    assign o_slot_index  = SLOT_W'(r_slot);
    assign o_task_count  = SLOT_W'(r_count);

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(ENTRIES), "live count above table size")
    `ASSERT_CLK(a_done_after_act, i_clk, i_rst_n, r_done |-> $past(r_state == S_ACT), "result without evaluation")
    `ASSERT_CLK(a_err_no_slot, i_clk, i_rst_n, (r_done && r_status != STAT_OK) |-> (r_slot == SLOT_NONE), "error result carries a slot")
    `ASSERT_CLK(a_create_grows, i_clk, i_rst_n, (r_done && r_cmd == CMD_CREATE && r_status == STAT_OK) |-> (r_count == $past(r_count) + CW'(1)), "create did not add an entry")

endmodule

// ----- hw/rtl/priority_ordered_task_table_core.sv -----
`timescale 1ns / 1ps
// A command taken while idle passes through capture, cell compare and apply; its result strobe
// follows the apply state. No new command is taken until the block is idle again; busy covers the
// compare and apply cycles. Results cannot be stalled by the receiver.
// Reset (synchronous, active low): table empty, all flags clear, min stack 32.
// Configuration writes are taken in any cycle and should only be issued while idle.
module priority_ordered_task_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_command,
    input  logic [7:0] i_task_id,
    input  logic [7:0] i_task_priority,
    input  logic [7:0] i_stack_bytes,
    input  logic       i_local_task,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_done,
    output logic [2:0] o_status_code,
    output logic [4:0] o_slot_index,
    output logic [4:0] o_task_count
);
    import pott_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    t_entry        w_entry [ENTRIES];
    t_entry        w_prev  [ENTRIES];
    t_entry        w_next  [ENTRIES];
    t_match        w_match [ENTRIES];
    t_op           w_op;
    logic [IW-1:0] w_pos;
    logic [7:0]    w_key_id;
    logic [7:0]    w_key_pri;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = ENTRY_EMPTY;
        end else begin : g_mid_prev
            assign w_prev[g] = w_entry[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign w_next[g] = ENTRY_EMPTY;
        end else begin : g_mid_next
            assign w_next[g] = w_entry[g+1];
        end

        pott_cell #(
            .ENTRIES (ENTRIES),
            .INDEX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key_id  (w_key_id),
            .i_key_pri (w_key_pri),
            .i_op      (w_op),
            .i_pos     (w_pos),
            .i_prev    (w_prev[g]),
            .i_next    (w_next[g]),
            .o_entry   (w_entry[g]),
            .o_match   (w_match[g])
        );
    end

    pott_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_command       (i_command),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_stack_bytes   (i_stack_bytes),
        .i_local_task    (i_local_task),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_match         (w_match),
        .o_key_id        (w_key_id),
        .o_key_pri       (w_key_pri),
        .o_op            (w_op),
        .o_pos           (w_pos),
        .o_done          (o_done),
        .o_status_code   (o_status_code),
        .o_slot_index    (o_slot_index),
        .o_task_count    (o_task_count)
    );

endmodule
